FILE: design/cdm_pkg.sv
// Shared types and constants of the crowding diversity metric unit.
// Used by cdm_div and crowding_diversity_metric_unit; depends on nothing.
package cdm_pkg;

	localparam int ID_W    = 10;
	localparam int OBJ_W   = 18;
	localparam int RATIO_W = 16;
	localparam int NOBJ_W  = 3;
	localparam int PROD_W  = 2 * RATIO_W;

	typedef struct packed {
		logic [ID_W-1:0]  member_id;
		logic [OBJ_W-1:0] objective_a;
		logic [OBJ_W-1:0] objective_b;
		logic [OBJ_W-1:0] objective_c;
		logic [OBJ_W-1:0] objective_d;
		logic             final_member;
	} cdm_in_t;

	typedef struct packed {
		logic [ID_W-1:0]  result_id;
		logic [OBJ_W-1:0] diversity;
		logic             is_infinite;
		logic             last_result;
	} cdm_out_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_DUP_I,
		ST_DUP_IW,
		ST_DUP_SCAN,
		ST_DUP_WR,
		ST_RNG_SCAN,
		ST_RNG_END,
		ST_M_I,
		ST_M_IW,
		ST_M_SCAN,
		ST_DIV_L_GO,
		ST_DIV_L_WT,
		ST_DIV_R_GO,
		ST_DIV_R_WT,
		ST_MUL,
		ST_ACC,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_HOLD
	} cdm_state_t;

endpackage

FILE: design/cdm_div.sv
// Gap over range divider giving a saturated Q0.16 ratio, one quotient bit per cycle.
// Depends on cdm_pkg.
module cdm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cdm_pkg::OBJ_W-1:0]   gap,
	input  logic [cdm_pkg::OBJ_W-1:0]   span,
	output logic                        done,
	output logic [cdm_pkg::RATIO_W-1:0] quotient
);
	import cdm_pkg::*;

	localparam int CNT_W = $clog2(RATIO_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [OBJ_W:0]     rem_q;
	logic [OBJ_W-1:0]   span_q;
	logic [RATIO_W-1:0] quo_q;
	logic [OBJ_W:0]     rem_dbl;
	logic               take;

	assign rem_dbl = {rem_q[OBJ_W-1:0], 1'b0};
	assign take    = rem_dbl >= {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (gap == span) begin
					done_q <= 1'b1;
					busy_q <= 1'b0;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(RATIO_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, gap};
			span_q <= span;
			quo_q  <= (gap == span) ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= take ? (rem_dbl - {1'b0, span_q}) : rem_dbl;
			quo_q <= {quo_q[RATIO_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: design/crowding_diversity_metric_unit.sv
// Crowding diversity metric unit: loads a member set, then emits one metric per member.
// Loading takes one member per cycle; in_stall is high from the final member to the last result.
// For more than two members, after the final one: a duplicate search, then per objective
// a range scan and, for a nonzero range, a neighbour scan per distinct member.
// Results follow one at a time, each held until out_stall is low. Reset clears control only.
// Depends on cdm_pkg and cdm_div.
module crowding_diversity_metric_unit #(
	parameter int MAX_POINTS     = 64,
	parameter int MAX_OBJECTIVES = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [cdm_pkg::NOBJ_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  cdm_pkg::cdm_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output cdm_pkg::cdm_out_t          out_data
);
	import cdm_pkg::*;

	localparam int PW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int OW  = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1;
	localparam int OCW = $clog2(MAX_OBJECTIVES + 1);

	typedef logic [MAX_OBJECTIVES-1:0][OBJ_W-1:0] row_t;

	cdm_state_t state_q, state_d;

	logic [NOBJ_W-1:0] num_obj_q;
	logic [OCW-1:0]    nobj_q;
	logic [OCW-1:0]    nobj_eff;
	logic [CW-1:0]     n_q, n_next;
	logic [CW-1:0]     i_q, j_q, d_q, d_next;
	logic [OW-1:0]     k_q;
	logic              all_inf_q, dist_inf_q;
	logic              match_q;
	row_t              cur_row_q;
	row_t              row_in;
	logic              vld_s1;
	logic [PW-1:0]     idx_s1;
	logic              have_q;
	logic [OBJ_W-1:0]  lo_q, hi_q, span_q, vi_q, pv_q, sv_q;
	logic              has_p_q, has_s_q;
	logic [RATIO_W-1:0] l_q, r_q;
	logic [PROD_W-1:0] prod_s1;
	logic              out_valid_q;
	cdm_out_t          out_q;

	row_t              obj_mem [MAX_POINTS];
	logic [ID_W-1:0]   id_mem [MAX_POINTS];
	logic              dist_mem [MAX_POINTS];
	logic [OBJ_W-1:0]  sums_mem [MAX_POINTS];
	row_t              row_rd;
	logic [ID_W-1:0]   id_rd;
	logic              dist_rd;
	logic [OBJ_W-1:0]  sums_rd;

	logic              in_acc, out_acc;
	logic              scanning, issue, scan_end;
	logic [CW-1:0]     scan_lim;
	logic [PW-1:0]     rd_addr;
	logic              dist_we, sums_we;
	logic [OBJ_W-1:0]  sums_wdata;
	logic [OBJ_W:0]    sum_ext;
	logic              div_start, div_done;
	logic [OBJ_W-1:0]  div_gap;
	logic [RATIO_W-1:0] div_q;
	logic              rows_eq;
	logic [OBJ_W-1:0]  vj;
	logic              key_less;
	logic              last_i, last_k, inf;
	logic [RATIO_W-1:0] mul_a, mul_b;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign n_next  = (n_q < CW'(MAX_POINTS)) ? n_q + CW'(1) : n_q;
	assign d_next  = d_q + CW'(!match_q);
	assign last_i  = (i_q + CW'(1)) == n_q;
	assign last_k  = (int'(k_q) + 1) == int'(nobj_q);
	assign vj      = row_rd[k_q];
	assign key_less = (vj < vi_q) || ((vj == vi_q) && (CW'(idx_s1) < i_q));
	assign inf     = all_inf_q || (dist_inf_q && dist_rd);
	assign mul_a   = has_p_q ? l_q : r_q;
	assign mul_b   = has_s_q ? r_q : l_q;
	assign sum_ext = {1'b0, sums_rd} + (OBJ_W + 1)'(prod_s1[PROD_W-1:RATIO_W]);

	always_comb begin
		if (num_obj_q == '0) begin
			nobj_eff = OCW'(1);
		end else if (32'(num_obj_q) > 32'(MAX_OBJECTIVES)) begin
			nobj_eff = OCW'(MAX_OBJECTIVES);
		end else begin
			nobj_eff = OCW'(num_obj_q);
		end
	end

	always_comb begin
		for (int o = 0; o < MAX_OBJECTIVES; o++) begin
			case (o)
				0:       row_in[o] = in_data.objective_a;
				1:       row_in[o] = in_data.objective_b;
				2:       row_in[o] = in_data.objective_c;
				3:       row_in[o] = in_data.objective_d;
				default: row_in[o] = '0;
			endcase
		end
	end

	always_comb begin
		rows_eq = 1'b1;
		for (int o = 0; o < MAX_OBJECTIVES; o++) begin
			if (o < int'(nobj_q) && row_rd[o] != cur_row_q[o]) begin
				rows_eq = 1'b0;
			end
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (in_acc && n_q < CW'(MAX_POINTS)) begin
			obj_mem[n_q[PW-1:0]] <= row_in;
			id_mem[n_q[PW-1:0]]  <= in_data.member_id;
		end
		row_rd <= obj_mem[rd_addr];
		id_rd  <= id_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[i_q[PW-1:0]] <= !match_q;
		end
		dist_rd <= dist_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (sums_we) begin
			sums_mem[i_q[PW-1:0]] <= sums_wdata;
		end
		sums_rd <= sums_mem[rd_addr];
	end

	cdm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.gap      (div_gap),
		.span     (span_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		in_stall   = state_q != ST_LOAD;
		scanning   = state_q == ST_DUP_SCAN || state_q == ST_RNG_SCAN || state_q == ST_M_SCAN;
		scan_lim   = (state_q == ST_DUP_SCAN) ? i_q : n_q;
		issue      = scanning && (j_q < scan_lim);
		scan_end   = scanning && !issue && !vld_s1;
		rd_addr    = scanning ? j_q[PW-1:0] : i_q[PW-1:0];
		dist_we    = state_q == ST_DUP_WR;
		sums_we    = state_q == ST_DUP_WR || state_q == ST_ACC;
		sums_wdata = '0;
		if (state_q == ST_ACC) begin
			sums_wdata = (sum_ext > (OBJ_W + 1)'({OBJ_W{1'b1}})) ? '1 : sum_ext[OBJ_W-1:0];
		end
		div_start  = state_q == ST_DIV_L_GO || state_q == ST_DIV_R_GO;
		div_gap    = '0;
		if (state_q == ST_DIV_L_GO && has_p_q) begin
			div_gap = vi_q - pv_q;
		end else if (state_q == ST_DIV_R_GO && has_s_q) begin
			div_gap = sv_q - vi_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && in_data.final_member) begin
					state_d = (n_next <= CW'(2)) ? ST_OUT_RD : ST_DUP_I;
				end
			end
			ST_DUP_I:    state_d = ST_DUP_IW;
			ST_DUP_IW:   state_d = ST_DUP_SCAN;
			ST_DUP_SCAN: begin
				if (scan_end) begin
					state_d = ST_DUP_WR;
				end
			end
			ST_DUP_WR: begin
				if (!last_i) begin
					state_d = ST_DUP_I;
				end else if (d_next <= CW'(2)) begin
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_RNG_SCAN;
				end
			end
			ST_RNG_SCAN: begin
				if (scan_end) begin
					state_d = ST_RNG_END;
				end
			end
			ST_RNG_END: begin
				if (hi_q != lo_q) begin
					state_d = ST_M_I;
				end else begin
					state_d = last_k ? ST_OUT_RD : ST_RNG_SCAN;
				end
			end
			ST_M_I:  state_d = ST_M_IW;
			ST_M_IW: begin
				if (dist_rd) begin
					state_d = ST_M_SCAN;
				end else if (!last_i) begin
					state_d = ST_M_I;
				end else begin
					state_d = last_k ? ST_OUT_RD : ST_RNG_SCAN;
				end
			end
			ST_M_SCAN: begin
				if (scan_end) begin
					state_d = ST_DIV_L_GO;
				end
			end
			ST_DIV_L_GO: state_d = ST_DIV_L_WT;
			ST_DIV_L_WT: begin
				if (div_done) begin
					state_d = ST_DIV_R_GO;
				end
			end
			ST_DIV_R_GO: state_d = ST_DIV_R_WT;
			ST_DIV_R_WT: begin
				if (div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_ACC;
			ST_ACC: begin
				if (!last_i) begin
					state_d = ST_M_I;
				end else begin
					state_d = last_k ? ST_OUT_RD : ST_RNG_SCAN;
				end
			end
			ST_OUT_RD:   state_d = ST_OUT_LD;
			ST_OUT_LD:   state_d = ST_OUT_HOLD;
			ST_OUT_HOLD: begin
				if (out_acc) begin
					state_d = last_i ? ST_LOAD : ST_OUT_RD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			num_obj_q   <= NOBJ_W'(2);
			n_q         <= '0;
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (cfg_we) begin
				num_obj_q <= cfg_wdata;
			end
			if (in_acc) begin
				n_q <= n_next;
			end
			if (state_q == ST_OUT_LD) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
				if (last_i) begin
					n_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= j_q[PW-1:0];
		if (issue) begin
			j_q <= j_q + CW'(1);
		end
		case (state_q)
			ST_LOAD: begin
				i_q       <= '0;
				d_q       <= '0;
				k_q       <= '0;
				j_q       <= '0;
				have_q    <= 1'b0;
				nobj_q    <= nobj_eff;
				dist_inf_q <= 1'b0;
				all_inf_q <= n_next <= CW'(2);
			end
			ST_DUP_IW: begin
				cur_row_q <= row_rd;
				match_q   <= 1'b0;
				j_q       <= '0;
			end
			ST_DUP_SCAN: begin
				if (vld_s1 && rows_eq) begin
					match_q <= 1'b1;
				end
			end
			ST_DUP_WR: begin
				d_q <= d_next;
				i_q <= last_i ? '0 : i_q + CW'(1);
				j_q <= '0;
				if (last_i && d_next <= CW'(2)) begin
					dist_inf_q <= 1'b1;
				end
			end
			ST_RNG_SCAN: begin
				if (vld_s1 && dist_rd) begin
					have_q <= 1'b1;
					if (!have_q || vj < lo_q) begin
						lo_q <= vj;
					end
					if (!have_q || vj > hi_q) begin
						hi_q <= vj;
					end
				end
			end
			ST_RNG_END: begin
				span_q <= hi_q - lo_q;
				i_q    <= '0;
				j_q    <= '0;
				have_q <= 1'b0;
				if (hi_q == lo_q) begin
					k_q <= k_q + OW'(1);
				end
			end
			ST_M_IW: begin
				vi_q    <= row_rd[k_q];
				has_p_q <= 1'b0;
				has_s_q <= 1'b0;
				j_q     <= '0;
				if (!dist_rd) begin
					i_q <= last_i ? '0 : i_q + CW'(1);
					if (last_i) begin
						k_q <= k_q + OW'(1);
					end
				end
			end
			ST_M_SCAN: begin
				if (vld_s1 && dist_rd && CW'(idx_s1) != i_q) begin
					if (key_less) begin
						if (!has_p_q || vj > pv_q) begin
							pv_q <= vj;
						end
						has_p_q <= 1'b1;
					end else begin
						if (!has_s_q || vj < sv_q) begin
							sv_q <= vj;
						end
						has_s_q <= 1'b1;
					end
				end
			end
			ST_DIV_L_WT: begin
				if (div_done) begin
					l_q <= div_q;
				end
			end
			ST_DIV_R_WT: begin
				if (div_done) begin
					r_q <= div_q;
				end
			end
			ST_MUL: begin
				prod_s1 <= mul_a * mul_b;
			end
			ST_ACC: begin
				i_q <= last_i ? '0 : i_q + CW'(1);
				j_q <= '0;
				if (last_i) begin
					k_q <= k_q + OW'(1);
				end
			end
			ST_OUT_LD: begin
				out_q.result_id   <= id_rd;
				out_q.diversity   <= inf ? '1 : sums_rd;
				out_q.is_infinite <= inf;
				out_q.last_result <= last_i;
			end
			ST_OUT_HOLD: begin
				if (out_acc) begin
					i_q <= i_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_out_only_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == ST_OUT_HOLD)
		else $error("result shown outside the hold state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(MAX_POINTS))
		else $error("member count beyond capacity");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_L_WT || state_q == ST_DIV_R_WT))
		else $error("divider finished with no state waiting");

	a_final_leaves_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_data.final_member) |=> state_q != ST_LOAD)
		else $error("final transaction did not start the computation");

endmodule
